// ===== sv/bmft_pkg.sv =====
// ============================================================================
// bmft_pkg
// Shared types and constants of the block-mapped flash translation unit.
// ============================================================================
`default_nettype none

package bmft_pkg;

    // Fixed widths of the host and command words.
    localparam int OP_W    = 1;
    localparam int LSN_W   = 6;
    localparam int CMD_W   = 3;
    localparam int ADDR_W  = 6;
    localparam int OWN_W   = 4;
    localparam int LSN_CNT = 2 ** LSN_W;

    // Host operations.
    localparam logic [OP_W-1:0] OP_READ  = 1'b0;
    localparam logic [OP_W-1:0] OP_WRITE = 1'b1;

    // Flash command codes.
    localparam logic [CMD_W-1:0] CMD_READ      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PROG      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MARK      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_COPY      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PROG_COPY = 3'd4;
    localparam logic [CMD_W-1:0] CMD_ERASE     = 3'd5;
    localparam logic [CMD_W-1:0] CMD_NO_BLOCK  = 3'd6;
    localparam logic [CMD_W-1:0] CMD_NO_PAGE   = 3'd7;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP,
        ST_ROW,
        ST_SCAN,
        ST_ERR,
        ST_READ,
        ST_MARK,
        ST_PROG,
        ST_COPY,
        ST_ERASE
    } t_state;

    // Strobes into the block map.
    typedef struct packed {
        logic rd;
        logic wr;
        logic claim;
        logic swap;
    } t_map_ctl;

    // Strobes into the written-page rows.
    typedef struct packed {
        logic rd;
        logic wr;
    } t_row_ctl;

endpackage

`default_nettype wire

// ===== sv/bmft_map.sv =====
// ============================================================================
// bmft_map
// Logical-to-physical block map, spare block register and in-use bitmap.
// ============================================================================
`default_nettype none

module bmft_map #(
    parameter int DATA_BLOCKS = 15,
    parameter int MI_W        = 4,
    parameter int PB_W        = 4
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  bmft_pkg::t_map_ctl      i_ctl,
    input  wire  [MI_W-1:0]         i_rd_idx,
    input  wire  [MI_W-1:0]         i_wr_idx,
    input  wire  [PB_W-1:0]         i_wr_pbn,
    input  wire  [PB_W-1:0]         i_new_spare,
    input  wire  [PB_W-1:0]         i_probe,
    output logic                    o_rd_valid,
    output logic [PB_W-1:0]         o_rd_pbn,
    output logic [PB_W-1:0]         o_spare,
    output logic                    o_probe_free
);

    localparam int NUM_PB = DATA_BLOCKS + 1;

    logic [PB_W-1:0]        r_mem [DATA_BLOCKS];
    logic [DATA_BLOCKS-1:0] r_vld;
    logic [NUM_PB-1:0]      r_used;
    logic [PB_W-1:0]        r_spare;
    logic [PB_W-1:0]        r_rd_data;
    logic                   r_rd_vld;

    // Map storage: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_wr_idx] <= i_wr_pbn;
        end
        if (i_ctl.rd) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    // Entry valid bits, used blocks and the spare. The spare always counts as used.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_used   <= NUM_PB'(1);
            r_spare  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_ctl.wr) begin
                r_vld[i_wr_idx] <= 1'b1;
            end
            if (i_ctl.claim) begin
                r_used[i_wr_pbn] <= 1'b1;
            end
            if (i_ctl.swap) begin
                r_spare <= i_new_spare;
            end
            if (i_ctl.rd) begin
                r_rd_vld <= r_vld[i_rd_idx];
            end
        end
    end

    assign o_rd_valid   = r_rd_vld;
    assign o_rd_pbn     = r_rd_data;
    assign o_spare      = r_spare;
    assign o_probe_free = !r_used[i_probe];

endmodule

`default_nettype wire

// ===== sv/bmft_rows.sv =====
// ============================================================================
// bmft_rows
// Written-page bitmap, stored as one row of page bits per physical block.
// ============================================================================
`default_nettype none

module bmft_rows #(
    parameter int NUM_PB      = 16,
    parameter int BLOCK_PAGES = 4,
    parameter int PB_W        = 4
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  bmft_pkg::t_row_ctl      i_ctl,
    input  wire  [PB_W-1:0]         i_rd_pbn,
    input  wire  [PB_W-1:0]         i_wr_pbn,
    input  wire  [BLOCK_PAGES-1:0]  i_wr_bits,
    output logic [BLOCK_PAGES-1:0]  o_rd_bits
);

    logic [BLOCK_PAGES-1:0] r_mem [NUM_PB];
    logic [NUM_PB-1:0]      r_vld;
    logic [BLOCK_PAGES-1:0] r_rd_data;
    logic                   r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_wr_pbn] <= i_wr_bits;
        end
        if (i_ctl.rd) begin
            r_rd_data <= r_mem[i_rd_pbn];
        end
    end

    // A row that was never written reads as all pages clear.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_ctl.wr) begin
                r_vld[i_wr_pbn] <= 1'b1;
            end
            if (i_ctl.rd) begin
                r_rd_vld <= r_vld[i_rd_pbn];
            end
        end
    end

    assign o_rd_bits = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

// ===== sv/block_mapped_flash_translation_unit.sv =====
// ============================================================================
// block_mapped_flash_translation_unit
// Block-mapped flash translation engine with one spare block.
//
// Each host word is a read or a write of one logical sector; the unit answers
// with a run of flash command words, the final one flagged by o_last. One
// host word is handled at a time: the input stalls from acceptance until the
// last command word of its run has been loaded into the output register.
// A read goes through a map lookup and a page-bit lookup and then gives one
// command word. A write to an unmapped block scans the in-use bitmap one
// physical block per cycle for the lowest free block and claims it. A write
// to a page that already holds data rewrites the block through the spare,
// with one copy command per page and then the erase. A stall on the output
// side holds the run in each state that emits a command word. The block map
// and the written-page rows sit in synchronous memories with a registered
// read; they need no clearing pass, since per-entry valid bits cleared at
// reset stand in for the erased state.
// ============================================================================
`default_nettype none

module block_mapped_flash_translation_unit #(
    parameter int DATA_BLOCKS = 15,
    parameter int BLOCK_PAGES = 4
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // Host request channel.
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  wire  [bmft_pkg::OP_W-1:0]       i_op,
    input  wire  [bmft_pkg::LSN_W-1:0]      i_lsn,
    // Flash command channel.
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output logic [bmft_pkg::CMD_W-1:0]      o_cmd,
    output logic [bmft_pkg::ADDR_W-1:0]     o_page_addr,
    output logic [bmft_pkg::ADDR_W-1:0]     o_src_addr,
    output logic [bmft_pkg::OWN_W-1:0]      o_owner_lbn,
    output logic [bmft_pkg::LSN_W-1:0]      o_lsn_tag,
    output logic                            o_last
);

    // Physical blocks are the data blocks plus the spare.
    localparam int NUM_PB = DATA_BLOCKS + 1;
    localparam int PB_W   = $clog2(NUM_PB);
    localparam int MI_W   = (DATA_BLOCKS > 1) ? $clog2(DATA_BLOCKS) : 1;
    localparam int OFF_W  = (BLOCK_PAGES > 1) ? $clog2(BLOCK_PAGES) : 1;

    localparam logic [bmft_pkg::LSN_W-1:0] LBN_LIMIT = bmft_pkg::LSN_W'(DATA_BLOCKS);
    localparam logic [OFF_W-1:0]           PAGE_LAST = OFF_W'(BLOCK_PAGES - 1);
    localparam logic [PB_W-1:0]            SCAN_LAST = PB_W'(NUM_PB - 1);

    // Physical page number of a page in a block, as carried on the command word.
    function automatic logic [bmft_pkg::ADDR_W-1:0] f_page(
        input logic [PB_W-1:0]  pbn,
        input logic [OFF_W-1:0] off
    );
        return bmft_pkg::ADDR_W'(int'(pbn) * BLOCK_PAGES + int'(off));
    endfunction

    // ------------------------------------------------------------------------
    // Sector to block and page split, as constant lookup tables built at
    // elaboration.
    // ------------------------------------------------------------------------
    logic [bmft_pkg::LSN_W-1:0] w_lbn_tab [bmft_pkg::LSN_CNT];
    logic [OFF_W-1:0]           w_off_tab [bmft_pkg::LSN_CNT];

    for (genvar g = 0; g < bmft_pkg::LSN_CNT; g++) begin : g_split
        assign w_lbn_tab[g] = bmft_pkg::LSN_W'(g / BLOCK_PAGES);
        assign w_off_tab[g] = OFF_W'(g % BLOCK_PAGES);
    end

    // ------------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------------
    bmft_pkg::t_state            r_state, n_state;
    logic [bmft_pkg::OP_W-1:0]   r_op, n_op;
    logic [bmft_pkg::LSN_W-1:0]  r_lsn, n_lsn;
    logic [bmft_pkg::LSN_W-1:0]  r_lbn, n_lbn;
    logic [OFF_W-1:0]            r_off, n_off;
    logic [PB_W-1:0]             r_pbn, n_pbn;
    logic [PB_W-1:0]             r_scan, n_scan;
    logic [OFF_W-1:0]            r_page, n_page;

    logic                        r_out_valid;
    logic [bmft_pkg::CMD_W-1:0]  r_cmd;
    logic [bmft_pkg::ADDR_W-1:0] r_page_addr;
    logic [bmft_pkg::ADDR_W-1:0] r_src_addr;
    logic [bmft_pkg::OWN_W-1:0]  r_owner_lbn;
    logic [bmft_pkg::LSN_W-1:0]  r_lsn_tag;
    logic                        r_last;

    // ------------------------------------------------------------------------
    // Combinational signals.
    // ------------------------------------------------------------------------
    logic                        w_accept;
    logic                        w_can_emit;
    logic [bmft_pkg::LSN_W-1:0]  w_lbn_in;
    logic [OFF_W-1:0]            w_off_in;
    logic [BLOCK_PAGES-1:0]      w_off_bit;
    logic                        w_hit;
    logic                        w_copy_target;

    logic                        e_valid;
    logic [bmft_pkg::CMD_W-1:0]  e_cmd;
    logic [bmft_pkg::ADDR_W-1:0] e_page;
    logic [bmft_pkg::ADDR_W-1:0] e_src;
    logic [bmft_pkg::OWN_W-1:0]  e_owner;
    logic [bmft_pkg::LSN_W-1:0]  e_tag;
    logic                        e_last;

    bmft_pkg::t_map_ctl          w_map_ctl;
    logic [MI_W-1:0]             w_map_rd_idx;
    logic [MI_W-1:0]             w_map_wr_idx;
    logic [PB_W-1:0]             w_map_wr_pbn;
    logic                        w_map_valid;
    logic [PB_W-1:0]             w_map_pbn;
    logic [PB_W-1:0]             w_spare;
    logic                        w_probe_free;

    bmft_pkg::t_row_ctl          w_row_ctl;
    logic [PB_W-1:0]             w_row_rd_pbn;
    logic [PB_W-1:0]             w_row_wr_pbn;
    logic [BLOCK_PAGES-1:0]      w_row_wr_bits;
    logic [BLOCK_PAGES-1:0]      w_row_bits;

    // A new host word is taken only when the sequencer is idle. The command
    // word register is loaded whenever it is empty or being taken.
    assign o_in_stall    = (r_state != bmft_pkg::ST_IDLE);
    assign w_accept      = i_in_valid && !o_in_stall;
    assign w_can_emit    = !r_out_valid || !i_out_stall;

    assign w_lbn_in      = w_lbn_tab[i_lsn];
    assign w_off_in      = w_off_tab[i_lsn];
    assign w_off_bit     = BLOCK_PAGES'(1) << r_off;
    assign w_hit         = w_row_bits[r_off];
    assign w_copy_target = (r_page == r_off);

    // ------------------------------------------------------------------------
    // State storage.
    // ------------------------------------------------------------------------
    bmft_map #(
        .DATA_BLOCKS (DATA_BLOCKS),
        .MI_W        (MI_W),
        .PB_W        (PB_W)
    ) u_map (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_map_ctl),
        .i_rd_idx     (w_map_rd_idx),
        .i_wr_idx     (w_map_wr_idx),
        .i_wr_pbn     (w_map_wr_pbn),
        .i_new_spare  (r_pbn),
        .i_probe      (r_scan),
        .o_rd_valid   (w_map_valid),
        .o_rd_pbn     (w_map_pbn),
        .o_spare      (w_spare),
        .o_probe_free (w_probe_free)
    );

    bmft_rows #(
        .NUM_PB      (NUM_PB),
        .BLOCK_PAGES (BLOCK_PAGES),
        .PB_W        (PB_W)
    ) u_rows (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_row_ctl),
        .i_rd_pbn  (w_row_rd_pbn),
        .i_wr_pbn  (w_row_wr_pbn),
        .i_wr_bits (w_row_wr_bits),
        .o_rd_bits (w_row_bits)
    );

    // ------------------------------------------------------------------------
    // Sequencer outputs: memory strobes and the command word to be loaded.
    // The row read issued in the map state (or at a claim) stays in the row
    // read register for the rest of the run, since no other row read happens
    // until the next host word.
    // ------------------------------------------------------------------------
    always_comb begin
        e_valid       = 1'b0;
        e_cmd         = bmft_pkg::CMD_READ;
        e_page        = '0;
        e_src         = '0;
        e_owner       = '0;
        e_tag         = '0;
        e_last        = 1'b0;
        w_map_ctl     = '0;
        w_map_rd_idx  = MI_W'(w_lbn_in);
        w_map_wr_idx  = MI_W'(r_lbn);
        w_map_wr_pbn  = r_scan;
        w_row_ctl     = '0;
        w_row_rd_pbn  = w_map_pbn;
        w_row_wr_pbn  = r_pbn;
        w_row_wr_bits = w_row_bits | w_off_bit;

        case (r_state)
            bmft_pkg::ST_IDLE: begin
                // Out-of-range sectors never look at the map.
                w_map_ctl.rd = w_accept && (w_lbn_in < LBN_LIMIT);
            end
            bmft_pkg::ST_MAP: begin
                w_row_ctl.rd = w_map_valid;
            end
            bmft_pkg::ST_SCAN: begin
                // Claim the probed block and fetch its (clear) page row.
                if (w_probe_free) begin
                    w_map_ctl.wr    = 1'b1;
                    w_map_ctl.claim = 1'b1;
                    w_row_ctl.rd    = 1'b1;
                    w_row_rd_pbn    = r_scan;
                end
            end
            bmft_pkg::ST_ROW: begin
            end
            bmft_pkg::ST_ERR: begin
                e_valid = 1'b1;
                e_cmd   = bmft_pkg::CMD_NO_BLOCK;
                e_last  = 1'b1;
            end
            bmft_pkg::ST_READ: begin
                e_valid = 1'b1;
                e_cmd   = w_hit ? bmft_pkg::CMD_READ : bmft_pkg::CMD_NO_PAGE;
                e_page  = f_page(r_pbn, r_off);
                e_last  = 1'b1;
            end
            bmft_pkg::ST_MARK: begin
                e_valid = 1'b1;
                e_cmd   = bmft_pkg::CMD_MARK;
                e_page  = f_page(r_pbn, '0);
                e_owner = bmft_pkg::OWN_W'(r_lbn);
            end
            bmft_pkg::ST_PROG: begin
                e_valid      = 1'b1;
                e_cmd        = bmft_pkg::CMD_PROG;
                e_page       = f_page(r_pbn, r_off);
                e_owner      = bmft_pkg::OWN_W'(r_lbn);
                e_tag        = r_lsn;
                e_last       = 1'b1;
                w_row_ctl.wr = w_can_emit;
            end
            bmft_pkg::ST_COPY: begin
                e_valid = 1'b1;
                e_page  = f_page(w_spare, r_page);
                e_src   = f_page(r_pbn, r_page);
                if (w_copy_target) begin
                    e_cmd   = bmft_pkg::CMD_PROG_COPY;
                    e_owner = bmft_pkg::OWN_W'(r_lbn);
                    e_tag   = r_lsn;
                end else begin
                    e_cmd   = bmft_pkg::CMD_COPY;
                end
                // The spare row takes the old row plus the target page.
                if (w_can_emit && (r_page == PAGE_LAST)) begin
                    w_row_ctl.wr = 1'b1;
                    w_row_wr_pbn = w_spare;
                end
            end
            bmft_pkg::ST_ERASE: begin
                e_valid      = 1'b1;
                e_cmd        = bmft_pkg::CMD_ERASE;
                e_page       = bmft_pkg::ADDR_W'(r_pbn);
                e_last       = 1'b1;
                w_map_wr_pbn = w_spare;
                // Old row clears, the spare takes the logical block, and the
                // old block becomes the spare.
                if (w_can_emit) begin
                    w_row_ctl.wr   = 1'b1;
                    w_row_wr_bits  = '0;
                    w_map_ctl.wr   = 1'b1;
                    w_map_ctl.swap = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Sequencer next state.
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_lsn   = r_lsn;
        n_lbn   = r_lbn;
        n_off   = r_off;
        n_pbn   = r_pbn;
        n_scan  = r_scan;
        n_page  = r_page;

        case (r_state)
            bmft_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_op    = i_op;
                    n_lsn   = i_lsn;
                    n_lbn   = w_lbn_in;
                    n_off   = w_off_in;
                    n_state = (w_lbn_in >= LBN_LIMIT) ? bmft_pkg::ST_ERR : bmft_pkg::ST_MAP;
                end
            end
            bmft_pkg::ST_MAP: begin
                if (!w_map_valid) begin
                    n_scan  = '0;
                    n_state = (r_op == bmft_pkg::OP_WRITE) ? bmft_pkg::ST_SCAN
                                                           : bmft_pkg::ST_ERR;
                end else begin
                    n_pbn   = w_map_pbn;
                    n_state = bmft_pkg::ST_ROW;
                end
            end
            bmft_pkg::ST_ROW: begin
                if (r_op == bmft_pkg::OP_READ) begin
                    n_state = bmft_pkg::ST_READ;
                end else if (!w_hit) begin
                    n_state = bmft_pkg::ST_PROG;
                end else begin
                    n_page  = '0;
                    n_state = bmft_pkg::ST_COPY;
                end
            end
            bmft_pkg::ST_SCAN: begin
                if (w_probe_free) begin
                    n_pbn   = r_scan;
                    n_state = bmft_pkg::ST_MARK;
                end else if (r_scan == SCAN_LAST) begin
                    n_state = bmft_pkg::ST_ERR;
                end else begin
                    n_scan  = r_scan + PB_W'(1);
                end
            end
            bmft_pkg::ST_MARK: begin
                if (w_can_emit) begin
                    n_state = bmft_pkg::ST_PROG;
                end
            end
            bmft_pkg::ST_COPY: begin
                if (w_can_emit) begin
                    if (r_page == PAGE_LAST) begin
                        n_state = bmft_pkg::ST_ERASE;
                    end else begin
                        n_page  = r_page + OFF_W'(1);
                    end
                end
            end
            bmft_pkg::ST_ERR,
            bmft_pkg::ST_READ,
            bmft_pkg::ST_PROG,
            bmft_pkg::ST_ERASE: begin
                if (w_can_emit) begin
                    n_state = bmft_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bmft_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Clocked state.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bmft_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_can_emit) begin
                r_out_valid <= e_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_lsn  <= n_lsn;
        r_lbn  <= n_lbn;
        r_off  <= n_off;
        r_pbn  <= n_pbn;
        r_scan <= n_scan;
        r_page <= n_page;
        if (w_can_emit && e_valid) begin
            r_cmd       <= e_cmd;
            r_page_addr <= e_page;
            r_src_addr  <= e_src;
            r_owner_lbn <= e_owner;
            r_lsn_tag   <= e_tag;
            r_last      <= e_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd       = r_cmd;
    assign o_page_addr = r_page_addr;
    assign o_src_addr  = r_src_addr;
    assign o_owner_lbn = r_owner_lbn;
    assign o_lsn_tag   = r_lsn_tag;
    assign o_last      = r_last;

endmodule

`default_nettype wire

// ===== tb/block_mapped_flash_translation_unit_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// block_mapped_flash_translation_unit_tb
// Self-checking regression of the block-mapped flash translation unit.
//
// Host words (read or write of one logical sector) are sent through the
// valid/stall request channel. Each accepted word is run through a local
// model of the translation state: block map, spare block and written-page
// bits. That model lists the flash command words the unit must answer with.
// A checker compares every accepted command word with the oldest listed one.
// Directed tests come first, then random traffic under three idling mixes.
// ============================================================================

module block_mapped_flash_translation_unit_tb;

    localparam int DATA_BLOCKS = 15;
    localparam int BLOCK_PAGES = 4;
    localparam int PHYS_BLOCKS = DATA_BLOCKS + 1;
    localparam int PHYS_PAGES  = PHYS_BLOCKS * BLOCK_PAGES;
    // The slowest word is a claim of the highest block, so a long quiet
    // stretch can only be a hang.
    localparam int QUIET_LIMIT = 2000;
    // Cycles to keep watching the command channel once nothing is expected.
    localparam int TAIL_CYCLES = 40;

    // One flash command word as seen on the output channel.
    typedef struct packed {
        logic [bmft_pkg::CMD_W-1:0]  cmd;
        logic [bmft_pkg::ADDR_W-1:0] page_addr;
        logic [bmft_pkg::ADDR_W-1:0] src_addr;
        logic [bmft_pkg::OWN_W-1:0]  owner_lbn;
        logic [bmft_pkg::LSN_W-1:0]  lsn_tag;
        logic                        last;
    } t_cmd_word;

    // ------------------------------------------------------------------------
    // Clock, reset and the signals around the unit. Every input starts at a
    // known value and is only changed by nonblocking assignments at the
    // rising edge, so outputs read right after the edge are the values the
    // unit itself sampled there.
    // ------------------------------------------------------------------------
    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_in_valid  = 1'b0;
    logic [bmft_pkg::OP_W-1:0]   i_op        = bmft_pkg::OP_READ;
    logic [bmft_pkg::LSN_W-1:0]  i_lsn       = '0;
    logic                        i_out_stall = 1'b0;
    logic                        o_in_stall;
    logic                        o_out_valid;
    logic [bmft_pkg::CMD_W-1:0]  o_cmd;
    logic [bmft_pkg::ADDR_W-1:0] o_page_addr;
    logic [bmft_pkg::ADDR_W-1:0] o_src_addr;
    logic [bmft_pkg::OWN_W-1:0]  o_owner_lbn;
    logic [bmft_pkg::LSN_W-1:0]  o_lsn_tag;
    logic                        o_last;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    block_mapped_flash_translation_unit #(
        .DATA_BLOCKS (DATA_BLOCKS),
        .BLOCK_PAGES (BLOCK_PAGES)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_lsn       (i_lsn),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (o_cmd),
        .o_page_addr (o_page_addr),
        .o_src_addr  (o_src_addr),
        .o_owner_lbn (o_owner_lbn),
        .o_lsn_tag   (o_lsn_tag),
        .o_last      (o_last)
    );

    // ------------------------------------------------------------------------
    // Translation state as the unit should hold it, and the command words
    // still owed by the unit, oldest first.
    // ------------------------------------------------------------------------
    bit         map_valid [DATA_BLOCKS];
    int         map_pbn   [DATA_BLOCKS];
    int         spare_pbn;
    bit         page_full [PHYS_PAGES];
    t_cmd_word  owed_cmds [$];

    int fail_count     = 0;
    int send_idle_pct  = 0;
    int stall_pct      = 0;

    function automatic t_cmd_word make_word(input logic [bmft_pkg::CMD_W-1:0] cmd,
                                            input int page, input int src,
                                            input int owner, input int tag);
        t_cmd_word w;
        w.cmd       = cmd;
        w.page_addr = page[bmft_pkg::ADDR_W-1:0];
        w.src_addr  = src[bmft_pkg::ADDR_W-1:0];
        w.owner_lbn = owner[bmft_pkg::OWN_W-1:0];
        w.lsn_tag   = tag[bmft_pkg::LSN_W-1:0];
        w.last      = 1'b0;
        return w;
    endfunction

    // A physical block is taken if it is the spare or some logical block
    // maps to it.
    function automatic bit block_taken(input int pbn);
        if (pbn == spare_pbn)
            return 1'b1;
        for (int i = 0; i < DATA_BLOCKS; i++)
            if (map_valid[i] && map_pbn[i] == pbn)
                return 1'b1;
        return 1'b0;
    endfunction

    // Works out the command run of one accepted host word, updates the
    // translation state and appends the run to the owed commands.
    task automatic predict_flash_commands(input logic [bmft_pkg::OP_W-1:0] op,
                                          input logic [bmft_pkg::LSN_W-1:0] lsn);
        t_cmd_word run [$];
        t_cmd_word w;
        int        lbn;
        int        off;
        int        pbn;
        int        ppn;
        int        src;
        int        dst;
        lbn = int'(lsn) / BLOCK_PAGES;
        off = int'(lsn) % BLOCK_PAGES;
        if (lbn >= DATA_BLOCKS) begin
            // Sector beyond the data blocks: refused for either operation.
            run.push_back(make_word(bmft_pkg::CMD_NO_BLOCK, 0, 0, 0, 0));
        end else if (op == bmft_pkg::OP_READ) begin
            if (!map_valid[lbn]) begin
                run.push_back(make_word(bmft_pkg::CMD_NO_BLOCK, 0, 0, 0, 0));
            end else begin
                ppn = map_pbn[lbn] * BLOCK_PAGES + off;
                run.push_back(make_word(page_full[ppn] ? bmft_pkg::CMD_READ
                                                       : bmft_pkg::CMD_NO_PAGE,
                                        ppn, 0, 0, 0));
            end
        end else if (!map_valid[lbn]) begin
            // Claim the lowest free physical block. One block is always free
            // here, since only the data blocks and the spare can be taken.
            pbn = 0;
            while (pbn < PHYS_BLOCKS && block_taken(pbn))
                pbn++;
            if (pbn >= PHYS_BLOCKS) begin
                run.push_back(make_word(bmft_pkg::CMD_NO_BLOCK, 0, 0, 0, 0));
            end else begin
                map_valid[lbn] = 1'b1;
                map_pbn[lbn]   = pbn;
                run.push_back(make_word(bmft_pkg::CMD_MARK, pbn * BLOCK_PAGES,
                                        0, lbn, 0));
                ppn = pbn * BLOCK_PAGES + off;
                page_full[ppn] = 1'b1;
                run.push_back(make_word(bmft_pkg::CMD_PROG, ppn, 0, lbn, int'(lsn)));
            end
        end else begin
            pbn = map_pbn[lbn];
            ppn = pbn * BLOCK_PAGES + off;
            if (!page_full[ppn]) begin
                page_full[ppn] = 1'b1;
                run.push_back(make_word(bmft_pkg::CMD_PROG, ppn, 0, lbn, int'(lsn)));
            end else begin
                // Rewrite of a full page: copy the block into the spare with
                // the host data in place of the target page, erase the old
                // block and swap the two roles.
                for (int i = 0; i < BLOCK_PAGES; i++) begin
                    src = pbn * BLOCK_PAGES + i;
                    dst = spare_pbn * BLOCK_PAGES + i;
                    if (i == off) begin
                        page_full[dst] = 1'b1;
                        run.push_back(make_word(bmft_pkg::CMD_PROG_COPY, dst, src,
                                                lbn, int'(lsn)));
                    end else begin
                        page_full[dst] = page_full[src];
                        run.push_back(make_word(bmft_pkg::CMD_COPY, dst, src, 0, 0));
                    end
                end
                for (int i = 0; i < BLOCK_PAGES; i++)
                    page_full[pbn * BLOCK_PAGES + i] = 1'b0;
                run.push_back(make_word(bmft_pkg::CMD_ERASE, pbn, 0, 0, 0));
                map_pbn[lbn] = spare_pbn;
                spare_pbn    = pbn;
            end
        end
        foreach (run[k]) begin
            w      = run[k];
            w.last = (k == run.size() - 1);
            owed_cmds.push_back(w);
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stall, and the checker of every accepted word.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin : cmd_checker
        t_cmd_word got;
        t_cmd_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.cmd       = o_cmd;
            got.page_addr = o_page_addr;
            got.src_addr  = o_src_addr;
            got.owner_lbn = o_owner_lbn;
            got.lsn_tag   = o_lsn_tag;
            got.last      = o_last;
            if (owed_cmds.size() == 0) begin
                $display("%0t: unexpected command word cmd=%0d page=%0d src=%0d",
                         $time, got.cmd, got.page_addr, got.src_addr);
                fail_count++;
            end else begin
                want = owed_cmds.pop_front();
                if (got != want) begin
                    $display("%0t: expected cmd=%0d page=%0d src=%0d own=%0d tag=%0d last=%0d",
                             $time, want.cmd, want.page_addr, want.src_addr,
                             want.owner_lbn, want.lsn_tag, want.last);
                    $display("%0t: actual   cmd=%0d page=%0d src=%0d own=%0d tag=%0d last=%0d",
                             $time, got.cmd, got.page_addr, got.src_addr,
                             got.owner_lbn, got.lsn_tag, got.last);
                    fail_count++;
                end
            end
        end
    end

    // Ends the run if neither channel moves a word for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("block_mapped_flash_translation_unit regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Request side.
    // ------------------------------------------------------------------------

    // Sends one host word after a random gap and returns at the edge that
    // accepted it. Valid is left high so that a following word can go out
    // back to back; whoever stops sending lowers it.
    task automatic send_host_word(input logic [bmft_pkg::OP_W-1:0] op,
                                  input logic [bmft_pkg::LSN_W-1:0] lsn);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_lsn      <= lsn;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predict_flash_commands(op, lsn);
    endtask

    // Stops sending and waits until every owed command word has arrived.
    task automatic wait_commands_drained();
        i_in_valid <= 1'b0;
        while (owed_cmds.size() != 0)
            @(posedge i_clk);
    endtask

    // Reads of unmapped and out-of-range sectors, and a write beyond the
    // data blocks, which must leave the state alone.
    task automatic test_unmapped_access();
        send_host_word(bmft_pkg::OP_READ,  6'd0);
        send_host_word(bmft_pkg::OP_READ,  6'd59);
        send_host_word(bmft_pkg::OP_READ,  6'd63);
        send_host_word(bmft_pkg::OP_WRITE, 6'd60);
        send_host_word(bmft_pkg::OP_READ,  6'd60);
    endtask

    // First writes claim blocks; the spare starts as block zero, so the
    // first claim lands on block one.
    task automatic test_block_claim();
        send_host_word(bmft_pkg::OP_WRITE, 6'd5);
        send_host_word(bmft_pkg::OP_READ,  6'd5);
        send_host_word(bmft_pkg::OP_READ,  6'd4);
        send_host_word(bmft_pkg::OP_WRITE, 6'd0);
    endtask

    // Writes to empty pages of a mapped block program them in place.
    task automatic test_page_program();
        send_host_word(bmft_pkg::OP_WRITE, 6'd4);
        send_host_word(bmft_pkg::OP_WRITE, 6'd6);
        send_host_word(bmft_pkg::OP_WRITE, 6'd7);
    endtask

    // Writes to full pages rewrite the block through the spare; the second
    // rewrite goes back into the block freed by the first.
    task automatic test_block_rewrite();
        send_host_word(bmft_pkg::OP_WRITE, 6'd5);
        send_host_word(bmft_pkg::OP_READ,  6'd4);
        send_host_word(bmft_pkg::OP_READ,  6'd7);
        send_host_word(bmft_pkg::OP_WRITE, 6'd6);
        send_host_word(bmft_pkg::OP_READ,  6'd6);
        send_host_word(bmft_pkg::OP_WRITE, 6'd0);
    endtask

    // Highest in-range sector, alternating bit patterns and the top code.
    task automatic test_field_extremes();
        send_host_word(bmft_pkg::OP_WRITE, 6'd59);
        send_host_word(bmft_pkg::OP_WRITE, 6'd59);
        send_host_word(bmft_pkg::OP_WRITE, 6'd42);
        send_host_word(bmft_pkg::OP_WRITE, 6'd21);
        send_host_word(bmft_pkg::OP_READ,  6'd42);
        send_host_word(bmft_pkg::OP_WRITE, 6'd63);
    endtask

    // Random traffic. Writes dominate so that blocks fill and get rewritten;
    // a share of the sectors sits in the first few blocks to make rewrites
    // frequent, and a few fall beyond the data blocks.
    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input int recv_pct);
        logic [bmft_pkg::OP_W-1:0]  op;
        logic [bmft_pkg::LSN_W-1:0] lsn;
        int                         pick;
        send_idle_pct = idle_pct;
        stall_pct     = recv_pct;
        for (int n = 0; n < count; n++) begin
            op   = ($urandom_range(99) < 60) ? bmft_pkg::OP_WRITE : bmft_pkg::OP_READ;
            pick = $urandom_range(99);
            if (pick < 5)
                lsn = bmft_pkg::LSN_W'($urandom_range(63, DATA_BLOCKS * BLOCK_PAGES));
            else if (pick < 45)
                lsn = bmft_pkg::LSN_W'($urandom_range(11));
            else
                lsn = bmft_pkg::LSN_W'($urandom_range(DATA_BLOCKS * BLOCK_PAGES - 1));
            send_host_word(op, lsn);
            // Halfway through, hold off until the unit has answered all.
            if (n == count / 2)
                wait_commands_drained();
        end
        wait_commands_drained();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        for (int i = 0; i < DATA_BLOCKS; i++) begin
            map_valid[i] = 1'b0;
            map_pbn[i]   = 0;
        end
        for (int i = 0; i < PHYS_PAGES; i++)
            page_full[i] = 1'b0;
        spare_pbn = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part runs under the first idling mix.
        send_idle_pct = 7;
        stall_pct     = 64;
        test_unmapped_access();
        test_block_claim();
        test_page_program();
        test_block_rewrite();
        test_field_extremes();
        wait_commands_drained();

        test_random_traffic(42, 7, 64);
        test_random_traffic(42, 64, 7);
        test_random_traffic(42, 0, 0);

        wait_commands_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("block_mapped_flash_translation_unit regression: pass");
        else
            $display("block_mapped_flash_translation_unit regression: fail");
        $finish;
    end

endmodule
